// ----- sv/permission_mode_string_parser_top_assert.svh -----
// assertion macros for the permission mode string parser
// needs clk and rst_n in the scope where the macros are used
`ifndef PERMISSION_MODE_STRING_PARSER_TOP_ASSERT_SVH
`define PERMISSION_MODE_STRING_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define PMSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PMSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/pmsp_pkg.sv -----
// shared types, codes and helpers of the permission mode string parser
// no dependencies
package pmsp_pkg;

  localparam logic [11:0] MODE_MASK = 12'o7777;
  localparam logic [2:0]  DIGIT_SAT = 3'd5;

  localparam logic [2:0] CLS_U = 3'b100;
  localparam logic [2:0] CLS_G = 3'b010;
  localparam logic [2:0] CLS_O = 3'b001;
  localparam logic [2:0] CLS_A = 3'b111;

  localparam logic [2:0] PERM_R = 3'b100;
  localparam logic [2:0] PERM_W = 3'b010;
  localparam logic [2:0] PERM_X = 3'b001;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_SET = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EXP_OP   = 2'd1;
  localparam logic [1:0] ST_EXP_PERM = 2'd2;
  localparam logic [1:0] ST_BAD_SEP  = 2'd3;

  typedef enum logic [2:0] {
    K_CLASS,
    K_OP,
    K_PERM,
    K_COMMA,
    K_OTHER
  } kind_t;

  typedef struct packed {
    logic        first;
    logic [11:0] cur_mode;
    logic        is_end;
    logic        is_digit;
    logic [2:0]  digit;
    kind_t       kind;
    logic [2:0]  bits;
  } tok_t;

  function automatic logic [11:0] spread(input logic [2:0] cls, input logic [2:0] rwx);
    logic [11:0] m;
    m = '0;
    if (cls[2]) m[8:6] = rwx;
    if (cls[1]) m[5:3] = rwx;
    if (cls[0]) m[2:0] = rwx;
    return m;
  endfunction

endpackage

// ----- sv/pmsp_front.sv -----
// front end: accepts characters and classifies them into tokens
// depends on pmsp_pkg
module pmsp_front import pmsp_pkg::*; (
  input  logic        in_push,
  input  logic [7:0]  in_character,
  input  logic        in_first_char,
  input  logic [11:0] in_current_mode,
  input  logic        q_full,
  output logic        q_wr,
  output tok_t        q_wdata
);

  always_comb begin
    q_wr              = in_push && !q_full;
    q_wdata.first     = in_first_char;
    q_wdata.cur_mode  = in_current_mode;
    q_wdata.is_end    = (in_character == 8'd0);
    q_wdata.is_digit  = (in_character >= "0") && (in_character <= "7");
    q_wdata.digit     = in_character[2:0];
    q_wdata.kind      = K_OTHER;
    q_wdata.bits      = '0;
    unique case (in_character)
      "u": begin q_wdata.kind = K_CLASS; q_wdata.bits = CLS_U; end
      "g": begin q_wdata.kind = K_CLASS; q_wdata.bits = CLS_G; end
      "o": begin q_wdata.kind = K_CLASS; q_wdata.bits = CLS_O; end
      "a": begin q_wdata.kind = K_CLASS; q_wdata.bits = CLS_A; end
      "+": begin q_wdata.kind = K_OP; q_wdata.bits = {1'b0, OP_ADD}; end
      "-": begin q_wdata.kind = K_OP; q_wdata.bits = {1'b0, OP_SUB}; end
      "=": begin q_wdata.kind = K_OP; q_wdata.bits = {1'b0, OP_SET}; end
      "r": begin q_wdata.kind = K_PERM; q_wdata.bits = PERM_R; end
      "w": begin q_wdata.kind = K_PERM; q_wdata.bits = PERM_W; end
      "x": begin q_wdata.kind = K_PERM; q_wdata.bits = PERM_X; end
      ",": q_wdata.kind = K_COMMA;
      default: q_wdata.kind = K_OTHER;
    endcase
  end

endmodule

// ----- sv/pmsp_queue.sv -----
// small register queue between the front end and the parser back end
// no dependencies
module pmsp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : PW'(wr_ptr_r + 1'b1);
    if (do_rd) rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : PW'(rd_ptr_r + 1'b1);
    if (do_wr && !do_rd) cnt_nxt = CW'(cnt_r + 1'b1);
    else if (do_rd && !do_wr) cnt_nxt = CW'(cnt_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

// ----- sv/pmsp_back.sv -----
// back end: parser state, clause apply, octal tracking and result register
// depends on pmsp_pkg
module pmsp_back import pmsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  tok_t        q_rdata,
  output logic        q_rd,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [11:0] out_new_mode,
  output logic [1:0]  out_status
);

  logic        phase_r, phase_nxt;
  logic [2:0]  cls_r, cls_nxt;
  logic        seen_r, seen_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [2:0]  perm_r, perm_nxt;
  logic        have_r, have_nxt;
  logic [11:0] wm_r, wm_nxt;
  logic [1:0]  err_r, err_nxt;
  logic [11:0] oct_r, oct_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        allo_r, allo_nxt;
  logic        ovld_r, ovld_nxt;
  logic [11:0] omode_r, omode_nxt;
  logic [1:0]  ost_r, ost_nxt;
  logic        stall;

  assign stall        = q_rdata.is_end && ovld_r && !out_pop;
  assign q_rd         = !q_empty && !stall;
  assign out_empty    = !ovld_r;
  assign out_new_mode = omode_r;
  assign out_status   = ost_r;

  always_comb begin
    logic [2:0] ecls;
    logic       close_ok;
    phase_nxt = phase_r;
    cls_nxt   = cls_r;
    seen_nxt  = seen_r;
    op_nxt    = op_r;
    perm_nxt  = perm_r;
    have_nxt  = have_r;
    wm_nxt    = wm_r;
    err_nxt   = err_r;
    oct_nxt   = oct_r;
    cnt_nxt   = cnt_r;
    allo_nxt  = allo_r;
    ovld_nxt  = ovld_r && !out_pop;
    omode_nxt = omode_r;
    ost_nxt   = ost_r;
    ecls      = '0;
    close_ok  = 1'b0;

    if (q_rd) begin
      if (q_rdata.first) begin
        phase_nxt = 1'b0;
        cls_nxt   = '0;
        seen_nxt  = 1'b0;
        op_nxt    = OP_ADD;
        perm_nxt  = '0;
        have_nxt  = 1'b0;
        err_nxt   = ST_OK;
        oct_nxt   = '0;
        cnt_nxt   = '0;
        allo_nxt  = 1'b1;
        wm_nxt    = q_rdata.cur_mode;
      end

      // clause close, shared by separators and the end of string
      ecls     = seen_nxt ? cls_nxt : CLS_A;
      close_ok = have_nxt || (op_nxt == OP_SET);

      if (!q_rdata.is_end) begin
        if (allo_nxt && q_rdata.is_digit) begin
          oct_nxt = {oct_nxt[8:0], q_rdata.digit};
          if (cnt_nxt < DIGIT_SAT) cnt_nxt = 3'(cnt_nxt + 1'b1);
        end else begin
          allo_nxt = 1'b0;
        end
        if (err_nxt == ST_OK) begin
          if (!phase_nxt) begin
            if (q_rdata.kind == K_CLASS) begin
              seen_nxt = 1'b1;
              cls_nxt  = cls_nxt | q_rdata.bits;
            end else if (q_rdata.kind == K_OP) begin
              op_nxt    = q_rdata.bits[1:0];
              phase_nxt = 1'b1;
            end else begin
              err_nxt = ST_EXP_OP;
            end
          end else if (q_rdata.kind == K_PERM) begin
            have_nxt = 1'b1;
            perm_nxt = perm_nxt | q_rdata.bits;
          end else if (!close_ok) begin
            err_nxt = ST_EXP_PERM;
          end else begin
            priority case (op_nxt)
              OP_SUB:  wm_nxt = wm_nxt & ~spread(ecls, perm_nxt);
              OP_SET:  wm_nxt = (wm_nxt & ~spread(ecls, 3'b111)) | spread(ecls, perm_nxt);
              default: wm_nxt = wm_nxt | spread(ecls, perm_nxt);
            endcase
            if (q_rdata.kind == K_COMMA) begin
              phase_nxt = 1'b0;
              cls_nxt   = '0;
              seen_nxt  = 1'b0;
              op_nxt    = OP_ADD;
              perm_nxt  = '0;
              have_nxt  = 1'b0;
            end else begin
              err_nxt = ST_BAD_SEP;
            end
          end
        end
      end else begin
        if (err_nxt == ST_OK) begin
          if (phase_nxt) begin
            if (!close_ok) begin
              err_nxt = ST_EXP_PERM;
            end else begin
              priority case (op_nxt)
                OP_SUB:  wm_nxt = wm_nxt & ~spread(ecls, perm_nxt);
                OP_SET:  wm_nxt = (wm_nxt & ~spread(ecls, 3'b111)) | spread(ecls, perm_nxt);
                default: wm_nxt = wm_nxt | spread(ecls, perm_nxt);
              endcase
            end
          end else if (seen_nxt) begin
            err_nxt = ST_EXP_OP;
          end
        end
        if (allo_nxt && (cnt_nxt == 3'd3 || cnt_nxt == 3'd4)) begin
          wm_nxt    = oct_nxt & MODE_MASK;
          omode_nxt = oct_nxt & MODE_MASK;
          ost_nxt   = ST_OK;
        end else if (err_nxt == ST_OK) begin
          omode_nxt = wm_nxt & MODE_MASK;
          ost_nxt   = ST_OK;
        end else begin
          omode_nxt = '0;
          ost_nxt   = err_nxt;
        end
        ovld_nxt  = 1'b1;
        phase_nxt = 1'b0;
        cls_nxt   = '0;
        seen_nxt  = 1'b0;
        op_nxt    = OP_ADD;
        perm_nxt  = '0;
        have_nxt  = 1'b0;
        err_nxt   = ST_OK;
        oct_nxt   = '0;
        cnt_nxt   = '0;
        allo_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      cls_r   <= '0;
      seen_r  <= 1'b0;
      op_r    <= OP_ADD;
      perm_r  <= '0;
      have_r  <= 1'b0;
      wm_r    <= '0;
      err_r   <= ST_OK;
      oct_r   <= '0;
      cnt_r   <= '0;
      allo_r  <= 1'b1;
      ovld_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cls_r   <= cls_nxt;
      seen_r  <= seen_nxt;
      op_r    <= op_nxt;
      perm_r  <= perm_nxt;
      have_r  <= have_nxt;
      wm_r    <= wm_nxt;
      err_r   <= err_nxt;
      oct_r   <= oct_nxt;
      cnt_r   <= cnt_nxt;
      allo_r  <= allo_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    omode_r <= omode_nxt;
    ost_r   <= ost_nxt;
  end

endmodule

// ----- sv/permission_mode_string_parser_top.sv -----
// top level of the permission mode string parser: front end, token queue, back end
// depends on pmsp_pkg, pmsp_front, pmsp_queue, pmsp_back and the assertion header
//
// Takes a mode string one character per transfer (0 ends it) and returns one
// result per string: the new 12-bit mode and a status. A character is taken every
// cycle unless the queue is full, and reaches the parser from the queue registers.
// The back end parses one queued token per cycle with registered state feedback,
// but holds an ending 0 until the last result is popped; the 0's result shows on
// out_ the cycle after it is read. Meanwhile the Q_DEPTH-entry queue takes input.
`include "permission_mode_string_parser_top_assert.svh"
module permission_mode_string_parser_top import pmsp_pkg::*; #(
  parameter int Q_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_character,
  input  logic        in_first_char,
  input  logic [11:0] in_current_mode,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [11:0] out_new_mode,
  output logic [1:0]  out_status
);

  logic q_wr, q_rd, q_empty;
  tok_t q_wdata, q_rdata;

  pmsp_front u_front (
    .in_push         (in_push),
    .in_character    (in_character),
    .in_first_char   (in_first_char),
    .in_current_mode (in_current_mode),
    .q_full          (in_full),
    .q_wr            (q_wr),
    .q_wdata         (q_wdata)
  );

  pmsp_queue #(
    .WIDTH ($bits(tok_t)),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (in_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  pmsp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_rdata      (q_rdata),
    .q_rd         (q_rd),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_new_mode (out_new_mode),
    .out_status   (out_status)
  );

  `PMSP_ASSERT_NOW(a_err_zero_mode, !out_empty && out_status != ST_OK, out_new_mode == 12'd0, "error result with nonzero mode")
  `PMSP_ASSERT_NOW(a_back_drains, !q_empty && out_empty, q_rd, "back end idle with work queued")
  `PMSP_ASSERT_NOW(a_full_nonempty, in_full, !q_empty, "queue full and empty at once")
  `PMSP_ASSERT_NEXT(a_end_result, q_rd && q_rdata.is_end, !out_empty, "end of string gave no result")

endmodule
